// ----- rtl/core/rgb2ypbpr_pkg.sv -----
// shared types, widths and coefficients of the rgb to ypbpr converter
package rgb2ypbpr_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int CH_W        = 16;
  localparam int MAX_W       = 16;
  localparam int NUM_CH      = 3;
  localparam int NUM_LANES   = 3;
  localparam int OUT_W       = FRAC_BITS + 1;
  localparam int Q_W         = FRAC_BITS + 1;
  localparam int COEF_W      = 21;
  localparam int ONE_W       = COEF_W - 1;
  localparam int PROD_W      = CH_W + 1 + COEF_W;
  localparam int SUM_W       = PROD_W + 2;
  // 1e6 * 65535 fits in 36 bits
  localparam int DEN_W       = 36;
  localparam int NUM_W       = DEN_W + FRAC_BITS;
  localparam int IN_DATA_W   = ((NUM_CH * CH_W + 7) / 8) * 8;
  localparam int OUT_DATA_W  = ((NUM_LANES * OUT_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_DATA_W - NUM_LANES * OUT_W;

  localparam logic [ONE_W-1:0] COEF_ONE      = ONE_W'(1000000);
  localparam logic [MAX_W-1:0] MAX_VAL_RESET = MAX_W'(255);

  // channel order in the input transfer
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  // lane order in the output transfer
  localparam int LANE_Y  = 0;
  localparam int LANE_PB = 1;
  localparam int LANE_PR = 2;

  typedef logic signed [COEF_W-1:0] coef_t;

  // coefficients in millionths, rows are lanes, columns are channels
  localparam coef_t COEF [NUM_LANES][NUM_CH] = '{
    '{ 21'sd299000,  21'sd587000,  21'sd114000},
    '{-21'sd168736, -21'sd331264,  21'sd500000},
    '{ 21'sd500000, -21'sd418688, -21'sd81312}
  };

  typedef struct packed {
    logic [MAX_W-1:0] max_val;
    logic [DEN_W-1:0] den;
  } cfg_t;

  typedef struct packed {
    logic             neg;
    logic [NUM_W-1:0] num;
  } lane_t;

  typedef struct packed {
    logic           neg;
    logic [Q_W-1:0] quo;
  } quo_t;

endpackage

// ----- rtl/core/rgb_to_ypbpr_converter_core.sv -----
// top level of the bt.601 rgb to ypbpr converter
//
// Input stream: one rgb pixel per transfer on in_tdata, red in the low bits.
// Output stream: one ypbpr result per pixel, in pixel order, as fixed point
// with 16 fractional bits: luma unsigned in [0, 1.0], blue_diff and
// red_diff two's complement in [-0.5, 0.5].
// Config port: cfg_data is the image maximum value; cfg_ready is always
// high and a write applies to every pixel taken after it. Write it only
// while no pixel is in flight.
//
// Throughput is one pixel per clock while the output is not stalled. The input
// transfer edge loads the first of 23 register stages: five to saturate, weigh,
// sum and round, then 17 divider stages (one quotient bit each), then the output
// register.
//
// Reset clears every valid bit and sets the maximum value to 255.
// When out_tready is low with a result waiting, the pipeline holds; an
// empty head stage still takes one more pixel, then in_tready drops.
module rgb_to_ypbpr_converter_core import rgb2ypbpr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // red, green, blue
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // luma, blue_diff, red_diff, zero pad
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [MAX_W-1:0]      cfg_data
);

  cfg_t                  cfg;
  logic                  adv;
  logic [CH_W-1:0]       chan [NUM_CH];
  logic                  num_valid;
  lane_t                 num  [NUM_LANES];
  logic                  quo_valid;
  quo_t                  quo  [NUM_LANES];
  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic [OUT_DATA_W-1:0] out_tdata_nxt;
  logic [OUT_W-1:0]      field [NUM_LANES];

  assign adv = !out_tvalid_r || out_tready;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      chan[c] = in_tdata[c*CH_W +: CH_W];
    end
  end

  rgb2ypbpr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rgb2ypbpr_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .chan      (chan),
    .num_valid (num_valid),
    .num       (num)
  );

  rgb2ypbpr_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .cfg       (cfg),
    .num_valid (num_valid),
    .num       (num),
    .quo_valid (quo_valid),
    .quo       (quo)
  );

  always_comb begin
    out_tdata_nxt = '0;
    for (int l = 0; l < NUM_LANES; l++) begin
      field[l] = quo[l].neg ? OUT_W'(-quo[l].quo) : OUT_W'(quo[l].quo);
      out_tdata_nxt[l*OUT_W +: OUT_W] = field[l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      out_tvalid_r <= quo_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ----- rtl/core/rgb2ypbpr_cfg.sv -----
// max value register and the derived divisor
module rgb2ypbpr_cfg import rgb2ypbpr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [MAX_W-1:0] cfg_data,
  output cfg_t             cfg
);

  logic [MAX_W-1:0] max_val_r;
  logic [DEN_W-1:0] den_r;
  logic [MAX_W-1:0] max_eff;
  logic [DEN_W-1:0] den_nxt;
  logic [DEN_W-1:0] den_rst;

  // a zero maximum divides by one million
  assign max_eff = (cfg_data == '0) ? MAX_W'(1) : cfg_data;
  assign den_nxt = DEN_W'(COEF_ONE) * DEN_W'(max_eff);
  assign den_rst = DEN_W'(COEF_ONE) * DEN_W'(MAX_VAL_RESET);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_val_r <= MAX_VAL_RESET;
      den_r     <= den_rst;
    end else if (cfg_valid) begin
      max_val_r <= cfg_data;
      den_r     <= den_nxt;
    end
  end

  assign cfg_ready   = 1'b1;
  assign cfg.max_val = max_val_r;
  assign cfg.den     = den_r;

endmodule

// ----- rtl/core/rgb2ypbpr_mac.sv -----
// saturate, weigh, sum and form the rounded dividend of each lane
module rgb2ypbpr_mac import rgb2ypbpr_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  cfg_t            cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [CH_W-1:0] chan [NUM_CH],
  output logic            num_valid,
  output lane_t           num [NUM_LANES]
);

  logic                     load;
  logic                     sat_v_r, prod_v_r, sum_v_r, mag_v_r, num_v_r;
  logic [CH_W-1:0]          sat_r    [NUM_CH];
  logic [CH_W-1:0]          sat_nxt  [NUM_CH];
  logic signed [PROD_W-1:0] prod_r   [NUM_LANES][NUM_CH];
  logic signed [PROD_W-1:0] prod_nxt [NUM_LANES][NUM_CH];
  logic signed [SUM_W-1:0]  sum_r    [NUM_LANES];
  logic signed [SUM_W-1:0]  sum_nxt  [NUM_LANES];
  logic [SUM_W-1:0]         abs_full [NUM_LANES];
  logic [DEN_W-1:0]         mag_r    [NUM_LANES];
  logic                     neg_r    [NUM_LANES];
  lane_t                    num_r    [NUM_LANES];
  lane_t                    num_nxt  [NUM_LANES];

  // the head stage may fill a bubble even while the rest is held
  assign load     = adv || !sat_v_r;
  assign in_ready = load;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      sat_nxt[c] = (chan[c] > cfg.max_val) ? cfg.max_val : chan[c];
    end
    for (int l = 0; l < NUM_LANES; l++) begin
      for (int c = 0; c < NUM_CH; c++) begin
        prod_nxt[l][c] = PROD_W'($signed({1'b0, sat_r[c]})) * PROD_W'(COEF[l][c]);
      end
      sum_nxt[l] = SUM_W'(prod_r[l][CH_RED]) + SUM_W'(prod_r[l][CH_GREEN])
                 + SUM_W'(prod_r[l][CH_BLUE]);
      abs_full[l] = sum_r[l][SUM_W-1] ? SUM_W'(-sum_r[l]) : SUM_W'(sum_r[l]);
      // half the divisor is added so the quotient rounds half away from zero
      num_nxt[l].neg = neg_r[l];
      num_nxt[l].num = {mag_r[l], {FRAC_BITS{1'b0}}} + NUM_W'(cfg.den >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_v_r <= 1'b0;
    end else if (load) begin
      sat_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
      sum_v_r  <= 1'b0;
      mag_v_r  <= 1'b0;
      num_v_r  <= 1'b0;
    end else if (adv) begin
      prod_v_r <= sat_v_r;
      sum_v_r  <= prod_v_r;
      mag_v_r  <= sum_v_r;
      num_v_r  <= mag_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sat_r <= sat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= prod_nxt;
      sum_r  <= sum_nxt;
      for (int l = 0; l < NUM_LANES; l++) begin
        mag_r[l] <= abs_full[l][DEN_W-1:0];
        neg_r[l] <= sum_r[l][SUM_W-1];
      end
      num_r <= num_nxt;
    end
  end

  assign num_valid = num_v_r;
  assign num       = num_r;

endmodule

// ----- rtl/core/rgb2ypbpr_div.sv -----
// pipelined restoring divider, one quotient bit per stage, three lanes
module rgb2ypbpr_div import rgb2ypbpr_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  adv,
  input  cfg_t  cfg,
  input  logic  num_valid,
  input  lane_t num [NUM_LANES],
  output logic  quo_valid,
  output quo_t  quo [NUM_LANES]
);

  logic             v_r      [Q_W];
  logic [DEN_W-1:0] rem_r    [Q_W-1][NUM_LANES];
  logic [Q_W-1:0]   low_r    [Q_W-1][NUM_LANES];
  logic [Q_W-1:0]   q_r      [Q_W][NUM_LANES];
  logic             neg_r    [Q_W][NUM_LANES];

  logic [DEN_W-1:0] rem_in   [Q_W][NUM_LANES];
  logic [Q_W-1:0]   low_in   [Q_W][NUM_LANES];
  logic [Q_W-1:0]   q_in     [Q_W][NUM_LANES];
  logic             neg_in   [Q_W][NUM_LANES];
  logic [DEN_W:0]   trial    [Q_W][NUM_LANES];
  logic [DEN_W:0]   diff     [Q_W][NUM_LANES];
  logic             hit      [Q_W][NUM_LANES];
  logic [DEN_W-1:0] rem_nxt  [Q_W-1][NUM_LANES];
  logic [Q_W-1:0]   low_nxt  [Q_W-1][NUM_LANES];
  logic [Q_W-1:0]   q_nxt    [Q_W][NUM_LANES];

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      // upper dividend bits are always below the divisor
      rem_in[0][l] = DEN_W'(num[l].num[NUM_W-1:Q_W]);
      low_in[0][l] = num[l].num[Q_W-1:0];
      q_in[0][l]   = '0;
      neg_in[0][l] = num[l].neg;
    end
    for (int k = 1; k < Q_W; k++) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        rem_in[k][l] = rem_r[k-1][l];
        low_in[k][l] = low_r[k-1][l];
        q_in[k][l]   = q_r[k-1][l];
        neg_in[k][l] = neg_r[k-1][l];
      end
    end
    for (int k = 0; k < Q_W; k++) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        trial[k][l] = {rem_in[k][l], low_in[k][l][Q_W-1]};
        diff[k][l]  = trial[k][l] - {1'b0, cfg.den};
        // no borrow means trial >= divisor
        hit[k][l]   = !diff[k][l][DEN_W];
        q_nxt[k][l] = {q_in[k][l][Q_W-2:0], hit[k][l]};
      end
    end
    for (int k = 0; k < Q_W - 1; k++) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        rem_nxt[k][l] = hit[k][l] ? diff[k][l][DEN_W-1:0] : trial[k][l][DEN_W-1:0];
        low_nxt[k][l] = {low_in[k][l][Q_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < Q_W; k++) begin
        v_r[k] <= 1'b0;
      end
    end else if (adv) begin
      v_r[0] <= num_valid;
      for (int k = 1; k < Q_W; k++) begin
        v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r <= rem_nxt;
      low_r <= low_nxt;
      q_r   <= q_nxt;
      neg_r <= neg_in;
    end
  end

  assign quo_valid = v_r[Q_W-1];

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      quo[l].neg = neg_r[Q_W-1][l];
      quo[l].quo = q_r[Q_W-1][l];
    end
  end

endmodule

// ----- rtl/core/rgb2ypbpr_checker.sv -----
// port level checks of the converter, bound to the top level
module rgb2ypbpr_checker import rgb2ypbpr_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  localparam logic [OUT_W-1:0]        LUMA_MAX = OUT_W'(1) << FRAC_BITS;
  localparam logic signed [OUT_W-1:0] DIFF_HI  = OUT_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [OUT_W-1:0] DIFF_LO  = -DIFF_HI;

  logic                       in_xfer, out_xfer;
  logic [5:0]                 pend_r;
  logic [5:0]                 pend_nxt;
  logic signed [OUT_W-1:0]    pb, pr;

  assign in_xfer  = in_tvalid && in_tready;
  assign out_xfer = out_tvalid && out_tready;
  assign pb       = $signed(out_tdata[LANE_PB*OUT_W +: OUT_W]);
  assign pr       = $signed(out_tdata[LANE_PR*OUT_W +: OUT_W]);

  always_comb begin
    pend_nxt = pend_r;
    if (in_xfer && !out_xfer) begin
      pend_nxt = pend_r + 6'd1;
    end else if (!in_xfer && out_xfer) begin
      pend_nxt = pend_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer |-> pend_r != '0)
    else $error("result transfer without a pending pixel");

  a_luma_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[LANE_Y*OUT_W +: OUT_W] <= LUMA_MAX)
    else $error("luma above one");

  a_diff_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pb <= DIFF_HI && pb >= DIFF_LO && pr <= DIFF_HI && pr >= DIFF_LO)
    else $error("chroma difference out of range");

endmodule

bind rgb_to_ypbpr_converter_core rgb2ypbpr_checker u_checker (.*);

// ----- tb/sv/rgb_to_ypbpr_converter_core_test.sv -----
// self-checking stream testbench for the rgb to ypbpr converter core
`timescale 1ns / 1ps

module rgb_to_ypbpr_converter_core_test;
  import rgb2ypbpr_pkg::*;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_ITEMS   = 55;
  localparam int NUM_PHASES    = 10;
  localparam int SQUEEZE_PHASE = 2;
  localparam int RANDOM_MAX    = -1;

  typedef struct packed {
    logic [OUT_W-1:0]        luma;
    logic signed [OUT_W-1:0] blue_diff;
    logic signed [OUT_W-1:0] red_diff;
  } ypbpr_t;

  typedef struct {
    logic [MAX_W-1:0] max_val;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    bit               typed;
    ypbpr_t           res;
  } pixel_row_t;

  localparam ypbpr_t WHITE = '{OUT_W'(65536), OUT_W'(0), OUT_W'(0)};
  localparam ypbpr_t BLACK = '{OUT_W'(0), OUT_W'(0), OUT_W'(0)};
  localparam ypbpr_t NONE  = '{OUT_W'(0), OUT_W'(0), OUT_W'(0)};

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [MAX_W-1:0]      cfg_data   = '0;

  ypbpr_t           pending_results[$];
  pixel_row_t       directed_rows[$];
  logic [MAX_W-1:0] cur_max         = MAX_W'(255);
  int               errors          = 0;
  int               pixels_sent     = 0;
  int               results_checked = 0;
  int               max_writes      = 0;
  int               cycles          = 0;
  bit               squeeze_req     = 1'b0;

  rgb_to_ypbpr_converter_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles", $time, cycles);
      $display("status: fail");
      $finish;
    end
  end

  // num * 2^FRAC_BITS / den, rounded half away from zero
  function automatic longint round_scaled(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = ((mag << FRAC_BITS) + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic ypbpr_t convert_pixel(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                           logic [CH_W-1:0] b, logic [MAX_W-1:0] maxv);
    longint cr;
    longint cg;
    longint cb;
    longint mv;
    longint den;
    ypbpr_t res;
    mv = maxv;
    cr = (r > maxv) ? mv : longint'(r);
    cg = (g > maxv) ? mv : longint'(g);
    cb = (b > maxv) ? mv : longint'(b);
    den = 64'd1000000 * ((mv == 0) ? 64'd1 : mv);
    res.luma      = OUT_W'(round_scaled(299000 * cr + 587000 * cg + 114000 * cb, den));
    res.blue_diff = OUT_W'(round_scaled(-168736 * cr - 331264 * cg + 500000 * cb, den));
    res.red_diff  = OUT_W'(round_scaled(500000 * cr - 418688 * cg - 81312 * cb, den));
    return res;
  endfunction

  // zero, the maximum, all ones, values around the maximum, in-range values and full random words
  function automatic logic [CH_W-1:0] pick_channel(logic [MAX_W-1:0] maxv);
    int t;
    case ($urandom_range(0, 5))
      0: return '0;
      1: return maxv;
      2: return '1;
      3: begin
        t = int'(maxv) + int'($urandom_range(0, 4)) - 2;
        if (t < 0) t = 0;
        if (t > 65535) t = 65535;
        return CH_W'(t);
      end
      4: return CH_W'($urandom_range(0, maxv));
      default: return CH_W'($urandom);
    endcase
  endfunction

  task automatic send_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                            input logic [CH_W-1:0] b, input int gap,
                            input bit typed, input ypbpr_t typed_res);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {b, g, r};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(typed ? typed_res : convert_pixel(r, g, b, cur_max));
    pixels_sent++;
  endtask

  // only written with the pipeline empty
  task automatic write_max_value(input logic [MAX_W-1:0] v);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_max = v;
    max_writes++;
  endtask

  task automatic check_result(input logic [OUT_DATA_W-1:0] data);
    ypbpr_t exp;
    ypbpr_t got;
    got.luma      = data[OUT_W-1:0];
    got.blue_diff = data[2*OUT_W-1:OUT_W];
    got.red_diff  = data[3*OUT_W-1:2*OUT_W];
    if (data[OUT_DATA_W-1:3*OUT_W] != '0) begin
      $display("%0t pad mismatch: expected 0, got %h", $time, data[OUT_DATA_W-1:3*OUT_W]);
      errors++;
    end
    if (pending_results.size() == 0) begin
      $display("%0t unexpected result: expected none, got luma %0d pb %0d pr %0d",
               $time, got.luma, got.blue_diff, got.red_diff);
      errors++;
      return;
    end
    exp = pending_results.pop_front();
    if (got.luma !== exp.luma) begin
      $display("%0t luma mismatch: expected %0d, got %0d", $time, exp.luma, got.luma);
      errors++;
    end
    if (got.blue_diff !== exp.blue_diff) begin
      $display("%0t blue_diff mismatch: expected %0d, got %0d", $time,
               exp.blue_diff, got.blue_diff);
      errors++;
    end
    if (got.red_diff !== exp.red_diff) begin
      $display("%0t red_diff mismatch: expected %0d, got %0d", $time,
               exp.red_diff, got.red_diff);
      errors++;
    end
    results_checked++;
  endtask

  // result side, with random stalls and one long hold-off
  initial begin
    int stall;
    bit rx_burst;
    rx_burst = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (results_checked % 40 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      stall = rx_burst ? 0 : $urandom_range(0, 19);
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      check_result(out_tdata);
    end
  end

  initial begin
    int phase_max[NUM_PHASES];
    int p;
    int i;
    bit tx_burst;
    logic [MAX_W-1:0] m;

    phase_max = '{255, 65535, RANDOM_MAX, 1023, 1, RANDOM_MAX, 0, 4095, RANDOM_MAX, 254};

    // first rows run on the reset value of the maximum
    directed_rows.push_back(pixel_row_t'{16'd255, 16'd0, 16'd0, 16'd0, 1'b1, BLACK});
    directed_rows.push_back(pixel_row_t'{16'd255, 16'd255, 16'd255, 16'd255, 1'b1, WHITE});
    directed_rows.push_back(pixel_row_t'{16'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, WHITE});
    directed_rows.push_back(pixel_row_t'{16'd255, 16'd255, 16'd0, 16'd0, 1'b0, NONE});
    directed_rows.push_back(pixel_row_t'{16'd255, 16'd0, 16'd255, 16'd0, 1'b0, NONE});
    directed_rows.push_back(pixel_row_t'{16'd255, 16'd0, 16'd0, 16'd255, 1'b0, NONE});
    directed_rows.push_back(pixel_row_t'{16'd255, 16'd256, 16'hFFFF, 16'd0, 1'b0, NONE});
    directed_rows.push_back(pixel_row_t'{16'd255, 16'd1, 16'd0, 16'd0, 1'b0, NONE});
    directed_rows.push_back(pixel_row_t'{16'd255, 16'd0, 16'd1, 16'd254, 1'b0, NONE});
    directed_rows.push_back(pixel_row_t'{16'd255, 16'h5555, 16'hAAAA, 16'h00FF, 1'b0, NONE});
    directed_rows.push_back(pixel_row_t'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, WHITE});
    directed_rows.push_back(pixel_row_t'{16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 1'b0, NONE});
    directed_rows.push_back(pixel_row_t'{16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 1'b0, NONE});
    directed_rows.push_back(pixel_row_t'{16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 1'b0, NONE});
    directed_rows.push_back(pixel_row_t'{16'hFFFF, 16'hAAAA, 16'h5555, 16'd1, 1'b0, NONE});
    directed_rows.push_back(pixel_row_t'{16'hFFFF, 16'd1, 16'd1, 16'd1, 1'b0, NONE});
    directed_rows.push_back(pixel_row_t'{16'd1, 16'd1, 16'd1, 16'd1, 1'b1, WHITE});
    directed_rows.push_back(pixel_row_t'{16'd1, 16'd0, 16'd1, 16'd0, 1'b0, NONE});
    directed_rows.push_back(pixel_row_t'{16'd1, 16'hFFFF, 16'd0, 16'hFFFF, 1'b0, NONE});
    // zero maximum saturates every channel to zero
    directed_rows.push_back(pixel_row_t'{16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, BLACK});
    directed_rows.push_back(pixel_row_t'{16'd0, 16'd0, 16'd0, 16'd0, 1'b1, BLACK});
    directed_rows.push_back(pixel_row_t'{16'd0, 16'd1, 16'd2, 16'd3, 1'b1, BLACK});

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[k]) begin
      if (directed_rows[k].max_val != cur_max) write_max_value(directed_rows[k].max_val);
      send_pixel(directed_rows[k].red, directed_rows[k].green, directed_rows[k].blue,
                 $urandom_range(0, 19), directed_rows[k].typed, directed_rows[k].res);
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      m = (phase_max[p] == RANDOM_MAX) ? MAX_W'($urandom_range(1, 65535))
                                       : MAX_W'(phase_max[p]);
      write_max_value(m);
      tx_burst = (p == SQUEEZE_PHASE) || ($urandom_range(0, 3) == 0);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        // back-to-back offers while the result side holds off
        if (p == SQUEEZE_PHASE && i == 4) squeeze_req = 1'b1;
        if (p != SQUEEZE_PHASE && i % 16 == 15) tx_burst = ($urandom_range(0, 3) == 0);
        send_pixel(pick_channel(m), pick_channel(m), pick_channel(m),
                   tx_burst ? 0 : $urandom_range(0, 19), 1'b0, NONE);
      end
    end

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d ypbpr results from %0d pixels over %0d max value writes",
             results_checked, pixels_sent, max_writes);
    $display("covered extremes, channel saturation, a zero maximum and a long output stall");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/rgb2ypbpr_pkg.sv
rtl/core/rgb2ypbpr_cfg.sv
rtl/core/rgb2ypbpr_mac.sv
rtl/core/rgb2ypbpr_div.sv
rtl/core/rgb_to_ypbpr_converter_core.sv
rtl/core/rgb2ypbpr_checker.sv
tb/sv/rgb_to_ypbpr_converter_core_test.sv
